/* rtl/lruc_pkg.sv */
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types and constants for the LRU set-associative tag store.
// ----------------------------------------------------------------------------
package lruc_pkg;

    // Default sizing
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_WIDTH   = 48;

    // Configuration register fields
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int SET_CFG_W    = 3;
    localparam int WAYS_CFG_W   = 4;
    localparam int OFFSET_CFG_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd2;

    // Stream fields
    localparam int MODE_W          = 2;
    localparam int MODE_MODIFY_BIT = 1;   // bit 1 set: load then store
    localparam int CNT_W           = 32;
    localparam int OUT_DATA_W      = 104; // 100 field bits padded to bytes

    typedef enum logic [1:0] {
        OUT_MISS  = 2'd0,
        OUT_HIT   = 2'd1,
        OUT_EVICT = 2'd2,
        OUT_NONE  = 2'd3
    } outcome_t;

    // Lookup status handed from the set update logic to the top level
    typedef struct packed {
        logic hit;
        logic evict;
    } lookup_status_t;

endpackage

/* rtl/lruc_ram.sv */
// ----------------------------------------------------------------------------
// lruc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lruc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lruc_set_update.sv */
// ----------------------------------------------------------------------------
// lruc_set_update
// Tag match and recency update for one set row: hit, fill or evict.
// ----------------------------------------------------------------------------
module lruc_set_update
    import lruc_pkg::*;
#(
    parameter int MAX_WAYS   = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
    localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int WAYS_W    = $clog2(MAX_WAYS + 1),
    localparam int ENTRY_W   = 1 + ADDR_WIDTH + RANK_W,
    localparam int ROW_W     = MAX_WAYS * ENTRY_W
) (
    input  logic                  row_ok,   // row written since last flush
    input  logic [ROW_W-1:0]      row_in,
    input  logic [ADDR_WIDTH-1:0] tag,
    input  logic [WAYS_W-1:0]     ways,     // already clamped to 1..MAX_WAYS
    output logic [ROW_W-1:0]      row_out,
    output lookup_status_t        status
);

    // Per-way entry fields
    logic [MAX_WAYS-1:0]   valid_in;
    logic [ADDR_WIDTH-1:0] tag_in  [MAX_WAYS];
    logic [RANK_W-1:0]     rank_in [MAX_WAYS];
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   match;

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w]   = (32'(w) < 32'(ways));
            valid_in[w] = row_ok & row_in[w*ENTRY_W] & in_use[w];
            tag_in[w]   = row_in[w*ENTRY_W+1 +: ADDR_WIDTH];
            rank_in[w]  = row_ok ? row_in[w*ENTRY_W+1+ADDR_WIDTH +: RANK_W] : '0;
            match[w]    = valid_in[w] & (tag_in[w] == tag);
        end
    end

    // Match select (lowest way wins), fill count, victim (highest way wins)
    logic [RANK_W-1:0] hit_way;
    logic [RANK_W-1:0] hit_rank;
    logic [WAYS_W-1:0] fill;
    logic [RANK_W-1:0] victim;
    logic [RANK_W-1:0] oldest;
    logic              hit;
    logic              full;

    assign oldest = RANK_W'(ways - WAYS_W'(1));
    assign hit    = |match;
    assign full   = (fill == ways);

    always_comb
    begin
        hit_way = '0;
        fill    = '0;
        victim  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = RANK_W'(w);
            end
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            fill = fill + WAYS_W'(valid_in[w]);
            if (in_use[w] && rank_in[w] == oldest)
            begin
                victim = RANK_W'(w);
            end
        end
    end

    assign hit_rank = rank_in[hit_way];

    // New row contents
    always_comb
    begin
        logic                  v_new;
        logic [ADDR_WIDTH-1:0] t_new;
        logic [RANK_W-1:0]     r_new;
        row_out = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            v_new = valid_in[w] | (row_ok & row_in[w*ENTRY_W]);
            t_new = tag_in[w];
            r_new = rank_in[w];
            if (hit)
            begin
                if (RANK_W'(w) == hit_way)
                begin
                    r_new = '0;
                end
                else if (valid_in[w] && rank_in[w] < hit_rank)
                begin
                    r_new = rank_in[w] + RANK_W'(1);
                end
            end
            else if (!full)
            begin
                if (32'(w) == 32'(fill))
                begin
                    v_new = 1'b1;
                    t_new = tag;
                    r_new = '0;
                end
                else if (valid_in[w])
                begin
                    r_new = rank_in[w] + RANK_W'(1);
                end
            end
            else
            begin
                if (RANK_W'(w) == victim)
                begin
                    t_new = tag;
                    r_new = '0;
                end
                else if (in_use[w])
                begin
                    r_new = rank_in[w] + RANK_W'(1);
                end
            end
            row_out[w*ENTRY_W +: ENTRY_W] = {r_new, t_new, v_new};
        end
    end

    assign status.hit   = hit;
    assign status.evict = !hit && full;

endmodule

/* rtl/lru_set_associative_cache_tags_top.sv */
// Timing: an accepted beat starts the lookup state while the set row is read from
//   the tag RAM; the lookup, which waits only while the previous result beat is
//   still unaccepted, writes the row back and loads the result register.
// Flow: one access at a time, loads, stores and modifies alike; a new beat waits for idle.
// Reset: configuration returns to 0 set bits, 1 way, 0 offset bits; counters and
//   per-set row flags clear at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// lru_set_associative_cache_tags_top
// Tag, valid and LRU store of a set-associative cache with running counters.
// ----------------------------------------------------------------------------
module lru_set_associative_cache_tags_top
    import lruc_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((ADDR_WIDTH+7)/8)*8-1:0]     s_tdata,  // address
    input  logic [MODE_W-1:0]                   s_tuser,  // mode
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // first_outcome, second_outcome, hit_total, miss_total, eviction_total
    output logic [OUT_DATA_W-1:0]               m_tdata,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYS_W   = $clog2(MAX_WAYS + 1);
    localparam int ENTRY_W  = 1 + ADDR_WIDTH + RANK_W;
    localparam int ROW_W    = MAX_WAYS * ENTRY_W;
    localparam int SHIFT_W  = 6;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t                  state_reg;
    logic [SET_CFG_W-1:0]    set_bits_reg;
    logic [WAYS_CFG_W-1:0]   ways_cfg_reg;
    logic [OFFSET_CFG_W-1:0] offset_bits_reg;
    logic [NUM_SETS-1:0]     row_ok_reg;
    logic [SET_W-1:0]        set_reg;
    logic [ADDR_WIDTH-1:0]   tag_reg;
    logic                    modify_reg;
    logic [CNT_W-1:0]        hit_reg;
    logic [CNT_W-1:0]        miss_reg;
    logic [CNT_W-1:0]        evict_reg;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;

    // Effective geometry
    logic [SET_CFG_W-1:0] set_bits_eff;
    logic [WAYS_W-1:0]    ways_eff;

    assign set_bits_eff = (32'(set_bits_reg) > MAX_SET_BITS) ?
                          SET_CFG_W'(MAX_SET_BITS) : set_bits_reg;

    always_comb
    begin
        if (ways_cfg_reg == '0)
        begin
            ways_eff = WAYS_W'(1);
        end
        else if (32'(ways_cfg_reg) > MAX_WAYS)
        begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAYS_W'(ways_cfg_reg);
        end
    end

    // Address split
    logic [ADDR_WIDTH-1:0] addr;
    logic [ADDR_WIDTH-1:0] addr_off;
    logic [SHIFT_W-1:0]    tag_shift;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_idx;
    logic [ADDR_WIDTH-1:0] tag_idx;

    assign addr      = s_tdata[ADDR_WIDTH-1:0];
    assign addr_off  = addr >> offset_bits_reg;
    assign tag_shift = SHIFT_W'(offset_bits_reg) + SHIFT_W'(set_bits_eff);
    assign set_mask  = ~({SET_W{1'b1}} << set_bits_eff);
    assign set_idx   = addr_off[SET_W-1:0] & set_mask;
    assign tag_idx   = addr >> tag_shift;

    // Handshakes
    logic in_beat;
    logic out_free;
    logic finish;
    logic cfg_beat;
    logic cfg_hit;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid & s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign finish    = (state_reg == ST_LOOK) && out_free;
    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid & cfg_ready;
    assign cfg_hit   = cfg_beat && (cfg_index == REG_SET_BITS ||
                                    cfg_index == REG_WAYS ||
                                    cfg_index == REG_OFFSET_BITS);

    // Tag RAM: one row per set
    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] row_wr;

    lruc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (finish),
        .waddr (set_reg),
        .wdata (row_wr),
        .re    (in_beat),
        .raddr (set_idx),
        .rdata (row_rd)
    );

    // Set update
    lookup_status_t status;

    lruc_set_update #(
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_set_update (
        .row_ok  (row_ok_reg[set_reg]),
        .row_in  (row_rd),
        .tag     (tag_reg),
        .ways    (ways_eff),
        .row_out (row_wr),
        .status  (status)
    );

    // Outcomes and saturating counters
    outcome_t         first_out;
    outcome_t         second_out;
    logic [1:0]       hit_inc;
    logic [CNT_W:0]   hit_sum;
    logic [CNT_W:0]   miss_sum;
    logic [CNT_W:0]   evict_sum;
    logic [CNT_W-1:0] hit_next;
    logic [CNT_W-1:0] miss_next;
    logic [CNT_W-1:0] evict_next;

    assign first_out  = status.hit ? OUT_HIT : (status.evict ? OUT_EVICT : OUT_MISS);
    // the store half of a modify always finds the block just installed
    assign second_out = modify_reg ? OUT_HIT : OUT_NONE;
    assign hit_inc    = 2'(status.hit) + 2'(modify_reg);
    assign hit_sum    = {1'b0, hit_reg} + (CNT_W+1)'(hit_inc);
    assign miss_sum   = {1'b0, miss_reg} + (CNT_W+1)'(!status.hit);
    assign evict_sum  = {1'b0, evict_reg} + (CNT_W+1)'(status.evict);
    assign hit_next   = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    assign miss_next  = miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
    assign evict_next = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];

    // Configuration registers and row flags; a register write flushes all lines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= '0;
            ways_cfg_reg    <= WAYS_CFG_W'(1);
            offset_bits_reg <= '0;
            row_ok_reg      <= '0;
        end
        else
        begin
            if (cfg_hit)
            begin
                row_ok_reg <= '0;
            end
            else if (finish)
            begin
                row_ok_reg[set_reg] <= 1'b1;
            end
            if (cfg_beat)
            begin
                unique case (cfg_index)
                    REG_SET_BITS:    set_bits_reg    <= cfg_data[SET_CFG_W-1:0];
                    REG_WAYS:        ways_cfg_reg    <= cfg_data[WAYS_CFG_W-1:0];
                    REG_OFFSET_BITS: offset_bits_reg <= cfg_data[OFFSET_CFG_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // Access item held during the lookup
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            set_reg    <= set_idx;
            tag_reg    <= tag_idx;
            modify_reg <= s_tuser[MODE_MODIFY_BIT];
        end
    end

    // Control state, counters and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hit_reg       <= '0;
            miss_reg      <= '0;
            evict_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (out_valid_reg && m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (in_beat)
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    if (finish)
                    begin
                        state_reg     <= ST_IDLE;
                        hit_reg       <= hit_next;
                        miss_reg      <= miss_next;
                        evict_reg     <= evict_next;
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {4'b0, evict_next, miss_next, hit_next,
                                          second_out, first_out};
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/lruc_checker.sv */
// ----------------------------------------------------------------------------
// lruc_checker
// Port-level checks on the tag store top level, bound to every instance.
// ----------------------------------------------------------------------------
module lruc_checker
    import lruc_pkg::*;
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [OUT_DATA_W-1:0]           m_tdata
);

    // One access in flight: the lookup cycle follows every accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted during lookup cycle");

    // A new result only appears right after a lookup cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without a preceding lookup");

    // The store half of a modify always hits; otherwise it reports none
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:2] == OUT_HIT || m_tdata[3:2] == OUT_NONE))
    else $error("bad second outcome");

    // The first access never reports none
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != OUT_NONE))
    else $error("bad first outcome");

    // Stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind lru_set_associative_cache_tags_top lruc_checker u_lruc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/lru_set_associative_cache_tags_top_test.sv */
// ----------------------------------------------------------------------------
// lru_set_associative_cache_tags_top_test
// Self-checking bench for the LRU tag store. A queue-fed driver streams
// accesses, and a predictor tracks valid bits, tags, ranks and counters.
// A monitor checks every result beat against the oldest prediction.
// Each phase reprograms the geometry and then runs hot-set traffic with
// bursty input and a patterned back-pressure on the result stream.
// ----------------------------------------------------------------------------
module lru_set_associative_cache_tags_top_test;
    import lruc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SET_BITS   = DEF_MAX_SET_BITS;
    localparam int MAX_WAYS       = DEF_MAX_WAYS;
    localparam int ADDR_WIDTH     = DEF_ADDR_WIDTH;
    localparam int NUM_LINES      = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 170;

    localparam logic [MODE_W-1:0] MODE_LOAD       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MODIFY     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MODIFY_ALT = 2'd3;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [ADDR_WIDTH-1:0] addr;
    } access_t;

    typedef struct packed {
        outcome_t    first;
        outcome_t    second;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } access_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ADDR_WIDTH-1:0] s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Bench-side queues
    access_t        access_queue[$];
    access_result_t pending_results[$];

    // Predicted block state
    logic [SET_CFG_W-1:0]    cfg_set_bits = '0;
    logic [WAYS_CFG_W-1:0]   cfg_ways = 4'd1;
    logic [OFFSET_CFG_W-1:0] cfg_offset_bits = '0;
    logic                    line_ok[NUM_LINES];
    logic [ADDR_WIDTH-1:0]   line_tags[NUM_LINES];
    logic [2:0]              line_rank[NUM_LINES];
    logic [31:0]             hit_total = '0;
    logic [31:0]             miss_total = '0;
    logic [31:0]             evict_total = '0;

    int mismatch_count = 0;
    int idle_cycles = 0;
    bit in_beat = 1'b0;

    lru_set_associative_cache_tags_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void flush_lines();
        for (int i = 0; i < NUM_LINES; i++)
        begin
            line_ok[i] = 1'b0;
            line_rank[i] = '0;
        end
    endfunction

    function automatic int active_ways();
        if (cfg_ways == 0)
            return 1;
        if (cfg_ways > MAX_WAYS)
            return MAX_WAYS;
        return int'(cfg_ways);
    endfunction

    function automatic int active_set_bits();
        return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_SET_BITS:    cfg_set_bits = value[SET_CFG_W-1:0];
            REG_WAYS:        cfg_ways = value[WAYS_CFG_W-1:0];
            REG_OFFSET_BITS: cfg_offset_bits = value[OFFSET_CFG_W-1:0];
            default:         return;   // no register, no flush
        endcase
        flush_lines();
    endfunction

    // One lookup in a set; updates valid bits, tags and ranks
    function automatic outcome_t touch_set(int set_idx, logic [ADDR_WIDTH-1:0] tag);
        int ways;
        int base;
        int filled;
        int victim;
        logic [2:0] old_rank;
        ways = active_ways();
        base = set_idx * MAX_WAYS;
        filled = 0;
        victim = 0;
        for (int w = 0; w < ways; w++)
        begin
            if (line_ok[base + w])
            begin
                filled++;
                if (line_tags[base + w] == tag)
                begin
                    old_rank = line_rank[base + w];
                    for (int k = 0; k < ways; k++)
                        if (line_ok[base + k] && line_rank[base + k] < old_rank)
                            line_rank[base + k]++;
                    line_rank[base + w] = '0;
                    return OUT_HIT;
                end
            end
        end
        // Free way left: age the others and fill the next slot
        if (filled < ways)
        begin
            for (int w = 0; w < ways; w++)
                if (line_ok[base + w])
                    line_rank[base + w]++;
            line_ok[base + filled] = 1'b1;
            line_tags[base + filled] = tag;
            line_rank[base + filled] = '0;
            return OUT_MISS;
        end
        // Set full: replace the oldest way
        for (int w = 0; w < ways; w++)
        begin
            if (line_rank[base + w] == 3'(ways - 1))
                victim = w;
            else
                line_rank[base + w]++;
        end
        line_tags[base + victim] = tag;
        line_rank[base + victim] = '0;
        return OUT_EVICT;
    endfunction

    function automatic void tally(outcome_t outcome);
        if (outcome == OUT_HIT)
        begin
            if (hit_total != '1)
                hit_total++;
        end
        else
        begin
            if (miss_total != '1)
                miss_total++;
            if (outcome == OUT_EVICT && evict_total != '1)
                evict_total++;
        end
    endfunction

    function automatic access_result_t predict_access(logic [MODE_W-1:0] mode,
                                                      logic [ADDR_WIDTH-1:0] addr);
        access_result_t res;
        int sbits;
        int set_idx;
        logic [ADDR_WIDTH-1:0] tag;
        sbits = active_set_bits();
        set_idx = int'((addr >> cfg_offset_bits) & ((48'd1 << sbits) - 48'd1));
        tag = addr >> (int'(cfg_offset_bits) + sbits);
        res.second = OUT_NONE;
        res.first = touch_set(set_idx, tag);
        tally(res.first);
        // modify: the store half hits the same block again
        if (mode[MODE_MODIFY_BIT])
        begin
            res.second = touch_set(set_idx, tag);
            tally(res.second);
        end
        res.hits = hit_total;
        res.misses = miss_total;
        res.evictions = evict_total;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Sampling at the rising edge: predict, check, watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        access_result_t want;
        in_beat = s_tvalid && s_tready;
        if (cfg_valid && cfg_ready)
            apply_register(cfg_index, cfg_data);
        if (in_beat)
            pending_results.push_back(predict_access(s_tuser, s_tdata));
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing expected", '0, '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.first)
                    report_mismatch("first_outcome", 32'(m_tdata[1:0]), 32'(want.first));
                if (m_tdata[3:2] !== want.second)
                    report_mismatch("second_outcome", 32'(m_tdata[3:2]), 32'(want.second));
                if (m_tdata[35:4] !== want.hits)
                    report_mismatch("hit_total", m_tdata[35:4], want.hits);
                if (m_tdata[67:36] !== want.misses)
                    report_mismatch("miss_total", m_tdata[67:36], want.misses);
                if (m_tdata[99:68] !== want.evictions)
                    report_mismatch("eviction_total", m_tdata[99:68], want.evictions);
            end
        end
        if (rst_n)
        begin
            if (in_beat || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("lru_set_associative_cache_tags_top verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input driver: bursts of beats with random gaps
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge clk)
    begin
        access_t next_item;
        if (rst_n && (!s_tvalid || in_beat))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (access_queue.size() > 0)
            begin
                next_item = access_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_item.addr;
                s_tuser <= next_item.mode;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result back-pressure: rotating ready pattern, renewed now and then
    // ------------------------------------------------------------------------
    logic [15:0] ready_pattern = 16'hFFFF;
    int stall_cycle = 0;

    always @(negedge clk)
    begin
        stall_cycle++;
        if (stall_cycle % 160 == 0)
        begin
            if ($urandom_range(0, 2) == 0)
                ready_pattern = 16'hFFFF;
            else
                ready_pattern = 16'($urandom) | 16'h0001;
        end
        m_tready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic logic [ADDR_WIDTH-1:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic push_access(logic [MODE_W-1:0] mode, logic [ADDR_WIDTH-1:0] addr);
        access_t item;
        item.mode = mode;
        item.addr = addr;
        access_queue.push_back(item);
    endtask

    // Block until every beat is sent and answered, then settle
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (access_queue.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Traffic aimed at a few hot sets so hits and evictions both occur
    task automatic run_random_phase(int n_items);
        int ways;
        int sbits;
        int offs;
        int hot_count;
        int pool_n;
        int pick;
        int hot_sets[4];
        int pool_set[$];
        logic [ADDR_WIDTH-1:0] pool_tag[$];
        logic [63:0] a;
        ways = active_ways();
        sbits = active_set_bits();
        offs = int'(cfg_offset_bits);
        hot_count = $urandom_range(1, 3);
        for (int i = 0; i < hot_count; i++)
            hot_sets[i] = $urandom & ((1 << sbits) - 1);
        pool_n = ways * hot_count + $urandom_range(0, 4);
        for (int i = 0; i < pool_n; i++)
        begin
            pool_set.push_back(hot_sets[$urandom_range(0, hot_count - 1)]);
            pool_tag.push_back(rand_addr());
        end
        @(posedge clk);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 99) < 12)
                push_access(2'($urandom_range(0, 3)), rand_addr());
            else
            begin
                pick = $urandom_range(0, pool_n - 1);
                a = (64'(pool_tag[pick]) << (offs + sbits))
                    | (64'(pool_set[pick]) << offs)
                    | (64'(rand_addr()) & ((64'd1 << offs) - 64'd1));
                push_access(2'($urandom_range(0, 3)), a[ADDR_WIDTH-1:0]);
            end
        end
        wait_idle();
    endtask

    // Fixed geometries first (extremes), random ones after
    logic [CFG_DATA_W-1:0] set_table[6]  = '{5'd6, 5'd31, 5'd0, 5'd3, 5'd1, 5'd6};
    logic [CFG_DATA_W-1:0] ways_table[6] = '{5'd8, 5'd16, 5'd8, 5'd15, 5'd2, 5'd1};
    logic [CFG_DATA_W-1:0] offs_table[6] = '{5'd4, 5'd31, 5'd0, 5'd16, 5'd12, 5'd0};

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry: one set, one way, no offset; tag is the address
        @(posedge clk);
        push_access(MODE_LOAD, 48'h0);
        push_access(MODE_LOAD, 48'h0);
        push_access(MODE_STORE, 48'h0);
        push_access(MODE_MODIFY, 48'h0);
        push_access(MODE_LOAD, 48'hFFFF_FFFF_FFFF);
        push_access(MODE_MODIFY_ALT, 48'hFFFF_FFFF_FFFF);
        push_access(MODE_MODIFY, 48'h5555_5555_5555);
        push_access(MODE_STORE, 48'hAAAA_AAAA_AAAA);
        push_access(MODE_MODIFY_ALT, 48'h0);
        wait_idle();

        // Write to the unused index must not flush the line
        write_register(REG_UNUSED, 5'h1F);
        @(posedge clk);
        push_access(MODE_LOAD, 48'h0);
        push_access(MODE_LOAD, 48'h1);
        wait_idle();

        // Widest offset: tag drops to the top address bits
        write_register(REG_OFFSET_BITS, 5'd31);
        @(posedge clk);
        push_access(MODE_LOAD, 48'h0000_7FFF_FFFF);
        push_access(MODE_LOAD, 48'h0);
        push_access(MODE_LOAD, 48'h0000_8000_0000);
        push_access(MODE_MODIFY, 48'hFFFF_FFFF_FFFF);
        wait_idle();

        // Set bits beyond the maximum, ways of zero
        write_register(REG_SET_BITS, 5'd7);
        write_register(REG_WAYS, 5'd16);
        @(posedge clk);
        push_access(MODE_LOAD, 48'hFFFF_FFFF_FFFF);
        push_access(MODE_LOAD, 48'h001F_FFFF_FFFF);
        push_access(MODE_MODIFY_ALT, 48'hFFFF_FFFF_FFFF);
        push_access(MODE_STORE, 48'h0020_0000_0000);
        push_access(MODE_LOAD, 48'h0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 6)
            begin
                write_register(REG_SET_BITS, set_table[p]);
                write_register(REG_WAYS, ways_table[p]);
                write_register(REG_OFFSET_BITS, offs_table[p]);
            end
            else
            begin
                write_register(REG_OFFSET_BITS, 5'($urandom_range(0, 31)));
                write_register(REG_WAYS, 5'($urandom_range(0, 31)));
                write_register(REG_SET_BITS, 5'($urandom_range(0, 31)));
                if ($urandom_range(0, 3) == 0)
                    write_register(REG_UNUSED, 5'($urandom_range(0, 31)));
            end
            run_random_phase(PHASE_ITEMS);
        end

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("lru_set_associative_cache_tags_top verification clean");
        else
            $display("lru_set_associative_cache_tags_top verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/lruc_pkg.sv
rtl/lruc_ram.sv
rtl/lruc_set_update.sv
rtl/lru_set_associative_cache_tags_top.sv
rtl/lruc_checker.sv
tb/lru_set_associative_cache_tags_top_test.sv
